// ===== sv/pufl_pkg.sv =====
// shared types, constants and filter codes for the png scanline unfilter
`timescale 1ns / 1ps

package pufl_pkg;

  // field and register widths
  localparam int BYTE_W     = 8;
  localparam int ROW_LEN_W  = 13;
  localparam int BPP_W      = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // default storage sizes
  localparam int MAX_ROW_BYTES_DEF   = 4096;
  localparam int MAX_PIXEL_BYTES_DEF = 4;

  // register indexes
  localparam logic REG_ROW_LENGTH      = 1'b0;
  localparam logic REG_BYTES_PER_PIXEL = 1'b1;

  // reset values of the registers
  localparam logic [ROW_LEN_W-1:0] ROW_LENGTH_RST      = ROW_LEN_W'(1);
  localparam logic [BPP_W-1:0]     BYTES_PER_PIXEL_RST = BPP_W'(1);

  // filter type codes
  localparam logic [BYTE_W-1:0] FILT_NONE    = 8'd0;
  localparam logic [BYTE_W-1:0] FILT_SUB     = 8'd1;
  localparam logic [BYTE_W-1:0] FILT_UP      = 8'd2;
  localparam logic [BYTE_W-1:0] FILT_AVERAGE = 8'd3;
  localparam logic [BYTE_W-1:0] FILT_PAETH   = 8'd4;

  // input request payload
  typedef struct packed {
    logic [BYTE_W-1:0] raw_byte;
    logic              image_start;
  } in_item_t;

  // result payload
  typedef struct packed {
    logic [BYTE_W-1:0] pixel_byte;
    logic              row_end;
  } out_item_t;

  // one data byte handed from the sequencer to the reconstruction stage
  typedef struct packed {
    logic [BYTE_W-1:0] raw_byte;
    logic [BYTE_W-1:0] filter;
    logic              first_row;
    logic              row_end;
  } recon_req_t;

endpackage

// ===== sv/pufl_row_mem.sv =====
// row store holding the previous reconstructed row, one write and one read port
`timescale 1ns / 1ps

module pufl_row_mem #(
  parameter int DEPTH = pufl_pkg::MAX_ROW_BYTES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [pufl_pkg::BYTE_W-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [pufl_pkg::BYTE_W-1:0] wr_data
);

  logic [pufl_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [pufl_pkg::BYTE_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/pufl_seq.sv =====
// row sequencer: configuration registers, filter byte capture and column tracking
`timescale 1ns / 1ps

module pufl_seq #(
  parameter int MAX_ROW_BYTES   = pufl_pkg::MAX_ROW_BYTES_DEF,
  parameter int MAX_PIXEL_BYTES = pufl_pkg::MAX_PIXEL_BYTES_DEF,
  parameter int AW              = $clog2(MAX_ROW_BYTES),
  parameter int HW              = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // accepted input request
  input  logic                            in_accept,
  input  pufl_pkg::in_item_t              in_data,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pufl_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pufl_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pufl_pkg::CFG_DATA_W-1:0] prdata,
  // to reconstruction stage and row store
  output logic                            req_valid,
  output pufl_pkg::recon_req_t            req,
  output logic [AW-1:0]                   req_idx,
  output logic                            clear_hist,
  output logic [HW-1:0]                   hist_sel
);

  localparam int CW  = pufl_pkg::ROW_LEN_W;
  localparam int LWM = $clog2(MAX_ROW_BYTES + 1);
  localparam int LW  = (LWM > CW + 1) ? LWM : CW + 1;
  localparam int PW  = $clog2(MAX_PIXEL_BYTES + 1);
  localparam int QW  = (PW > pufl_pkg::BPP_W) ? PW : pufl_pkg::BPP_W;

  logic [CW-1:0]                   row_length_r, row_length_nxt;
  logic [pufl_pkg::BPP_W-1:0]      bpp_r, bpp_nxt;
  logic [CW-1:0]                   column_r, column_nxt;
  logic [pufl_pkg::BYTE_W-1:0]     filter_r, filter_nxt;
  logic                            expect_r, expect_nxt;
  logic                            first_row_r, first_row_nxt;

  logic                            cfg_wr;
  logic                            cfg_idx;
  logic [LW-1:0]                   len_raw;
  logic [LW-1:0]                   len_eff;
  logic [LW-1:0]                   col_inc;
  logic [QW-1:0]                   bpp_raw;
  logic [QW-1:0]                   bpp_eff;
  logic [QW-1:0]                   bpp_dec;
  logic [AW+CW-1:0]                idx_ext;
  logic                            is_filter;
  logic                            last;

  // register write decode
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[2];

  always_comb begin
    row_length_nxt = row_length_r;
    bpp_nxt        = bpp_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        pufl_pkg::REG_ROW_LENGTH:      row_length_nxt = pwdata[CW-1:0];
        pufl_pkg::REG_BYTES_PER_PIXEL: bpp_nxt        = pwdata[pufl_pkg::BPP_W-1:0];
        default: ;
      endcase
    end
  end

  // register read mux
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      pufl_pkg::REG_ROW_LENGTH:      prdata = pufl_pkg::CFG_DATA_W'(row_length_r);
      pufl_pkg::REG_BYTES_PER_PIXEL: prdata = pufl_pkg::CFG_DATA_W'(bpp_r);
      default:                       prdata = '0;
    endcase
  end

  // effective row length: zero means one, saturate at the row store depth
  assign len_raw = LW'(row_length_r);
  always_comb begin
    if (len_raw == '0) begin
      len_eff = LW'(1);
    end else if (len_raw > LW'(MAX_ROW_BYTES)) begin
      len_eff = LW'(MAX_ROW_BYTES);
    end else begin
      len_eff = len_raw;
    end
  end

  // effective left distance: zero means one, saturate at the history depth
  assign bpp_raw = QW'(bpp_r);
  always_comb begin
    if (bpp_raw == '0) begin
      bpp_eff = QW'(1);
    end else if (bpp_raw > QW'(MAX_PIXEL_BYTES)) begin
      bpp_eff = QW'(MAX_PIXEL_BYTES);
    end else begin
      bpp_eff = bpp_raw;
    end
  end
  assign bpp_dec  = bpp_eff - QW'(1);
  assign hist_sel = bpp_dec[HW-1:0];

  // row position
  assign is_filter = in_data.image_start || expect_r;
  assign col_inc   = LW'(column_r) + LW'(1);
  assign last      = (col_inc >= len_eff);
  assign idx_ext   = {{AW{1'b0}}, column_r};

  always_comb begin
    column_nxt    = column_r;
    filter_nxt    = filter_r;
    expect_nxt    = expect_r;
    first_row_nxt = first_row_r;
    if (in_accept) begin
      if (is_filter) begin
        filter_nxt = in_data.raw_byte;
        column_nxt = '0;
        expect_nxt = 1'b0;
        if (in_data.image_start) begin
          first_row_nxt = 1'b1;
        end
      end else if (last) begin
        column_nxt    = '0;
        expect_nxt    = 1'b1;
        first_row_nxt = 1'b0;
      end else begin
        column_nxt = col_inc[CW-1:0];
      end
    end
  end

  // data byte request toward the reconstruction stage
  assign req_valid      = in_accept && !is_filter;
  assign clear_hist     = in_accept && is_filter;
  assign req.raw_byte   = in_data.raw_byte;
  assign req.filter     = filter_r;
  assign req.first_row  = first_row_r;
  assign req.row_end    = last;
  assign req_idx        = idx_ext[AW-1:0];

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= pufl_pkg::ROW_LENGTH_RST;
      bpp_r        <= pufl_pkg::BYTES_PER_PIXEL_RST;
      column_r     <= '0;
      filter_r     <= '0;
      expect_r     <= 1'b1;
      first_row_r  <= 1'b1;
    end else begin
      row_length_r <= row_length_nxt;
      bpp_r        <= bpp_nxt;
      column_r     <= column_nxt;
      filter_r     <= filter_nxt;
      expect_r     <= expect_nxt;
      first_row_r  <= first_row_nxt;
    end
  end

endmodule

// ===== sv/pufl_recon.sv =====
// reconstruction stage: neighbor histories, filter arithmetic and result register
`timescale 1ns / 1ps

module pufl_recon #(
  parameter int MAX_PIXEL_BYTES = pufl_pkg::MAX_PIXEL_BYTES_DEF,
  parameter int AW              = 12,
  parameter int HW              = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // from the sequencer
  input  logic                          req_valid,
  input  pufl_pkg::recon_req_t          req,
  input  logic [AW-1:0]                 req_idx,
  input  logic                          clear_hist,
  input  logic [HW-1:0]                 hist_sel,
  output logic                          busy_stall,
  // row store
  input  logic [pufl_pkg::BYTE_W-1:0]   above_byte,
  output logic                          wr_en,
  output logic [AW-1:0]                 wr_addr,
  output logic [pufl_pkg::BYTE_W-1:0]   wr_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output pufl_pkg::out_item_t           out_data
);

  localparam int BW = pufl_pkg::BYTE_W;

  logic                  s1_valid_r, s1_valid_nxt;
  pufl_pkg::recon_req_t  s1_req_r;
  logic [AW-1:0]         s1_idx_r;
  logic [BW-1:0]         left_hist_r [MAX_PIXEL_BYTES];
  logic [BW-1:0]         ul_hist_r   [MAX_PIXEL_BYTES];
  logic                  out_valid_r, out_valid_nxt;
  pufl_pkg::out_item_t   out_data_r;

  logic                  s1_adv;
  logic [BW-1:0]         a, b, c;
  logic [BW-1:0]         pa, pb;
  logic [BW:0]           ab_sum;
  logic [BW:0]           c2;
  logic [BW:0]           pc;
  logic [BW-1:0]         paeth;
  logic [BW-1:0]         recon;

  // stage handshake
  assign s1_adv     = s1_valid_r && (!out_valid_r || !out_stall);
  assign busy_stall = s1_valid_r && !s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (req_valid) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // neighbors of the byte in the stage
  assign b = s1_req_r.first_row ? '0 : above_byte;
  assign a = left_hist_r[hist_sel];
  assign c = ul_hist_r[hist_sel];

  // paeth predictor, ties to a then b
  assign ab_sum = {1'b0, a} + {1'b0, b};
  assign c2     = {c, 1'b0};
  assign pa     = (b >= c) ? (b - c) : (c - b);
  assign pb     = (a >= c) ? (a - c) : (c - a);
  assign pc     = (ab_sum >= c2) ? (ab_sum - c2) : (c2 - ab_sum);

  always_comb begin
    if (({1'b0, pa} <= {1'b0, pb}) && ({1'b0, pa} <= pc)) begin
      paeth = a;
    end else if ({1'b0, pb} <= pc) begin
      paeth = b;
    end else begin
      paeth = c;
    end
  end

  // filter select, unknown codes pass through
  always_comb begin
    case (s1_req_r.filter)
      pufl_pkg::FILT_NONE:    recon = s1_req_r.raw_byte;
      pufl_pkg::FILT_SUB:     recon = s1_req_r.raw_byte + a;
      pufl_pkg::FILT_UP:      recon = s1_req_r.raw_byte + b;
      pufl_pkg::FILT_AVERAGE: recon = s1_req_r.raw_byte + ab_sum[BW:1];
      pufl_pkg::FILT_PAETH:   recon = s1_req_r.raw_byte + paeth;
      default:                recon = s1_req_r.raw_byte;
    endcase
  end

  // row store write back
  assign wr_en   = s1_adv;
  assign wr_addr = s1_idx_r;
  assign wr_data = recon;

  // result register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers and histories
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        left_hist_r[k] <= '0;
        ul_hist_r[k]   <= '0;
      end
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (clear_hist) begin
        for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
          left_hist_r[k] <= '0;
          ul_hist_r[k]   <= '0;
        end
      end else if (s1_adv) begin
        for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
          left_hist_r[k] <= left_hist_r[k-1];
          ul_hist_r[k]   <= ul_hist_r[k-1];
        end
        left_hist_r[0] <= recon;
        ul_hist_r[0]   <= b;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_valid) begin
      s1_req_r <= req;
      s1_idx_r <= req_idx;
    end
    if (s1_adv) begin
      out_data_r.pixel_byte <= recon;
      out_data_r.row_end    <= s1_req_r.row_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/png_scanline_unfilter_unit.sv =====
// top level of the png scanline unfilter: sequencer, row store and reconstruction stage
`timescale 1ns / 1ps

// Reconstructs an inflated PNG image stream at one byte per clock. The input takes a request
// in every cycle unless the reconstruction stage holds a byte that cannot move on because the
// result register is full and stalled. A filter type byte gives no result; a data byte's
// result moves from the reconstruction stage into the result register, where it is taken.
// The byte above is read from the single-port-read row store at the accept edge and used,
// together with the left and upper-left histories, by the reconstruction stage, whose
// result lands in the output register. The row store has no reset: a row longer than every
// earlier row since reset reads unwritten entries. Registers: row_length at byte 0,
// bytes_per_pixel at byte 4; write them only while the block is idle.

module png_scanline_unfilter_unit #(
  parameter int MAX_ROW_BYTES   = pufl_pkg::MAX_ROW_BYTES_DEF,
  parameter int MAX_PIXEL_BYTES = pufl_pkg::MAX_PIXEL_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  pufl_pkg::in_item_t              in_data,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output pufl_pkg::out_item_t             out_data,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pufl_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pufl_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pufl_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int AW = $clog2(MAX_ROW_BYTES);
  localparam int HW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  logic                          in_accept;
  logic                          req_valid;
  pufl_pkg::recon_req_t          req;
  logic [AW-1:0]                 req_idx;
  logic                          clear_hist;
  logic [HW-1:0]                 hist_sel;
  logic [pufl_pkg::BYTE_W-1:0]   above_byte;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic [pufl_pkg::BYTE_W-1:0]   wr_data;

  // input request acceptance
  assign in_accept = in_valid && !in_stall;
  assign pready    = 1'b1;

  // row sequencer and registers
  pufl_seq #(
    .MAX_ROW_BYTES  (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES(MAX_PIXEL_BYTES),
    .AW             (AW),
    .HW             (HW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_data   (in_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .req_valid (req_valid),
    .req       (req),
    .req_idx   (req_idx),
    .clear_hist(clear_hist),
    .hist_sel  (hist_sel)
  );

  // previous row store
  pufl_row_mem #(
    .DEPTH(MAX_ROW_BYTES),
    .AW   (AW)
  ) u_row_mem (
    .clk    (clk),
    .rd_en  (req_valid),
    .rd_addr(req_idx),
    .rd_data(above_byte),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  // reconstruction stage and result register
  pufl_recon #(
    .MAX_PIXEL_BYTES(MAX_PIXEL_BYTES),
    .AW             (AW),
    .HW             (HW)
  ) u_recon (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req       (req),
    .req_idx   (req_idx),
    .clear_hist(clear_hist),
    .hist_sel  (hist_sel),
    .busy_stall(in_stall),
    .above_byte(above_byte),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== tb/sv/png_scanline_unfilter_unit_tb.sv =====
// self-checking testbench for the png scanline unfilter: byte stream against a row tracker
`timescale 1ns / 1ps

// tracks row reconstruction and the pixel bytes the block still owes
class scanline_tracker;
  logic [pufl_pkg::ROW_LEN_W-1:0] row_length;
  logic [pufl_pkg::BPP_W-1:0]     pixel_bytes;
  logic [pufl_pkg::BYTE_W-1:0]    prev_row [pufl_pkg::MAX_ROW_BYTES_DEF];
  logic [pufl_pkg::BYTE_W-1:0]    left_hist [pufl_pkg::MAX_PIXEL_BYTES_DEF];
  logic [pufl_pkg::BYTE_W-1:0]    upleft_hist [pufl_pkg::MAX_PIXEL_BYTES_DEF];
  logic [pufl_pkg::BYTE_W-1:0]    filter;
  int                             column;
  bit                             await_filter;
  bit                             first_row;
  int                             store_fill;
  pufl_pkg::out_item_t            owed_pixels [$];
  int                             errors;

  function new();
    row_length   = pufl_pkg::ROW_LENGTH_RST;
    pixel_bytes  = pufl_pkg::BYTES_PER_PIXEL_RST;
    foreach (left_hist[k]) left_hist[k] = '0;
    foreach (upleft_hist[k]) upleft_hist[k] = '0;
    filter       = pufl_pkg::FILT_NONE;
    column       = 0;
    await_filter = 1'b1;
    first_row    = 1'b1;
    store_fill   = 0;
    errors       = 0;
  endfunction

  function void write_reg(logic idx, logic [pufl_pkg::CFG_DATA_W-1:0] value);
    if (idx == pufl_pkg::REG_ROW_LENGTH) row_length = value[pufl_pkg::ROW_LEN_W-1:0];
    else pixel_bytes = value[pufl_pkg::BPP_W-1:0];
  endfunction

  // zero falls back to one, large values saturate
  function int eff_row_len();
    if (row_length == 0) return 1;
    if (row_length > pufl_pkg::MAX_ROW_BYTES_DEF) return pufl_pkg::MAX_ROW_BYTES_DEF;
    return int'(row_length);
  endfunction

  function int pixel_step();
    if (pixel_bytes == 0) return 1;
    if (pixel_bytes > pufl_pkg::MAX_PIXEL_BYTES_DEF) return pufl_pkg::MAX_PIXEL_BYTES_DEF;
    return int'(pixel_bytes);
  endfunction

  function int store_index();
    return (column < pufl_pkg::MAX_ROW_BYTES_DEF) ? column : pufl_pkg::MAX_ROW_BYTES_DEF - 1;
  endfunction

  // a data byte now would read a row store entry never written
  function bit reads_unwritten();
    return !await_filter && !first_row && store_index() >= store_fill;
  endfunction

  // paeth predictor, ties go to left then above
  function logic [pufl_pkg::BYTE_W-1:0] paeth(int a, int b, int c);
    int pa, pb, pc;
    pa = (b > c) ? b - c : c - b;
    pb = (a > c) ? a - c : c - a;
    pc = (a + b > 2 * c) ? a + b - 2 * c : 2 * c - a - b;
    if (pa <= pb && pa <= pc) return pufl_pkg::BYTE_W'(a);
    if (pb <= pc) return pufl_pkg::BYTE_W'(b);
    return pufl_pkg::BYTE_W'(c);
  endfunction

  // apply one accepted request and queue the pixel it causes
  function void take_byte(pufl_pkg::in_item_t req);
    int                          idx, step, a, b, c;
    logic [pufl_pkg::BYTE_W-1:0] x, r;
    pufl_pkg::out_item_t         px;
    if (req.image_start) first_row = 1'b1;
    // filter type byte, also forced by image start in mid row
    if (req.image_start || await_filter) begin
      filter = req.raw_byte;
      column = 0;
      foreach (left_hist[k]) left_hist[k] = '0;
      foreach (upleft_hist[k]) upleft_hist[k] = '0;
      await_filter = 1'b0;
      return;
    end
    idx  = store_index();
    step = pixel_step();
    x    = req.raw_byte;
    b    = first_row ? 0 : int'(prev_row[idx]);
    a    = (column >= step) ? int'(left_hist[step-1]) : 0;
    c    = (column >= step) ? int'(upleft_hist[step-1]) : 0;
    case (filter)
      pufl_pkg::FILT_SUB:     r = x + pufl_pkg::BYTE_W'(a);
      pufl_pkg::FILT_UP:      r = x + pufl_pkg::BYTE_W'(b);
      pufl_pkg::FILT_AVERAGE: r = x + pufl_pkg::BYTE_W'((a + b) >> 1);
      pufl_pkg::FILT_PAETH:   r = x + paeth(a, b, c);
      default:                r = x;
    endcase
    prev_row[idx] = r;
    if (idx >= store_fill) store_fill = idx + 1;
    for (int k = pufl_pkg::MAX_PIXEL_BYTES_DEF - 1; k > 0; k--) begin
      left_hist[k]   = left_hist[k-1];
      upleft_hist[k] = upleft_hist[k-1];
    end
    left_hist[0]   = r;
    upleft_hist[0] = pufl_pkg::BYTE_W'(b);
    px.pixel_byte  = r;
    px.row_end     = (column + 1 >= eff_row_len());
    if (px.row_end) begin
      column       = 0;
      await_filter = 1'b1;
      first_row    = 1'b0;
    end else begin
      column = column + 1;
    end
    owed_pixels.push_back(px);
  endfunction

  // compare one accepted result with the oldest owed pixel
  function void check_pixel(pufl_pkg::out_item_t got);
    pufl_pkg::out_item_t want;
    if (owed_pixels.size() == 0) begin
      $display("%0t: result with none expected, actual pixel_byte %02h row_end %0b",
               $time, got.pixel_byte, got.row_end);
      errors++;
      return;
    end
    want = owed_pixels.pop_front();
    if (got.pixel_byte !== want.pixel_byte) begin
      $display("%0t: pixel_byte expected %02h actual %02h",
               $time, want.pixel_byte, got.pixel_byte);
      errors++;
    end
    if (got.row_end !== want.row_end) begin
      $display("%0t: row_end expected %0b actual %0b", $time, want.row_end, got.row_end);
      errors++;
    end
  endfunction
endclass

module png_scanline_unfilter_unit_tb;

  localparam int TAIL_CYCLES    = 4;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_REQUESTS = 150;
  // about 1.5k requests in all, with a limit many times over what they need
  localparam int CYCLE_LIMIT    = 1000000;

  localparam logic [pufl_pkg::BYTE_W-1:0] FILT_UNKNOWN_LO = pufl_pkg::FILT_PAETH + 8'd1;
  localparam logic [pufl_pkg::BYTE_W-1:0] FILT_UNKNOWN_HI = '1;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  pufl_pkg::in_item_t              in_data;
  logic                            out_valid;
  logic                            out_stall;
  pufl_pkg::out_item_t             out_data;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [pufl_pkg::CFG_ADDR_W-1:0] paddr;
  logic [pufl_pkg::CFG_DATA_W-1:0] pwdata;
  logic [pufl_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  bit              no_gaps;
  bit              hold_results;
  int              cycles = 0;
  scanline_tracker tracker;

  png_scanline_unfilter_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // offer one request after a random gap, note it once accepted
  task automatic send(logic [pufl_pkg::BYTE_W-1:0] raw, logic start);
    int                 gap;
    pufl_pkg::in_item_t req;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    req.raw_byte    = raw;
    req.image_start = start;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    tracker.take_byte(req);
    @(negedge clk);
  endtask

  // stop offering, wait for every owed pixel, then wait out the given tail
  task automatic drain(int tail);
    in_valid <= 1'b0;
    do @(negedge clk); while (tracker.owed_pixels.size() != 0);
    repeat (tail) @(negedge clk);
  endtask

  // register write: setup then access cycle
  task automatic cfg_write(logic idx, logic [pufl_pkg::CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= pufl_pkg::CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    tracker.write_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // mostly well-formed rows, with new images and rows cut by image start
  function automatic pufl_pkg::in_item_t next_request(int new_image_pct, int cut_pct,
                                                      bit open_image);
    pufl_pkg::in_item_t req;
    bit                 start;
    if (tracker.await_filter) start = ($urandom_range(0, 99) < new_image_pct);
    else start = ($urandom_range(0, 99) < cut_pct);
    start = start || open_image || tracker.reads_unwritten();
    if (start || tracker.await_filter)
      req.raw_byte = ($urandom_range(0, 6) == 0)
                     ? pufl_pkg::BYTE_W'($urandom)
                     : pufl_pkg::BYTE_W'($urandom_range(pufl_pkg::FILT_NONE,
                                                        pufl_pkg::FILT_PAETH));
    else
      req.raw_byte = pufl_pkg::BYTE_W'($urandom);
    req.image_start = start;
    return req;
  endfunction

  // result side: random stall per result, one long hold when asked
  initial begin : result_sink
    int wait_cycles;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_results) begin
        wait_cycles  = HOLD_CYCLES;
        hold_results = 1'b0;
      end else if (no_gaps) begin
        wait_cycles = 0;
      end else begin
        wait_cycles = $urandom_range(0, 10);
      end
      out_stall <= (wait_cycles != 0);
      if (wait_cycles != 0) begin
        repeat (wait_cycles) @(negedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      tracker.check_pixel(out_data);
      @(negedge clk);
    end
  end

  // stimulus
  initial begin : stimulus
    int                 len;
    pufl_pkg::in_item_t req;
    tracker      = new();
    no_gaps      = 1'b0;
    hold_results = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero row length and zero pixel size fall back to one
    cfg_write(pufl_pkg::REG_ROW_LENGTH, '0);
    cfg_write(pufl_pkg::REG_BYTES_PER_PIXEL, '0);
    send(pufl_pkg::FILT_NONE, 1'b1);
    send(8'hff, 1'b0);
    send(pufl_pkg::FILT_UP, 1'b0);
    send(8'h00, 1'b0);

    // oversized pixel saturates, sub, average and paeth filters, image start in mid row, unknown filter
    drain(TAIL_CYCLES);
    cfg_write(pufl_pkg::REG_ROW_LENGTH, 5);
    cfg_write(pufl_pkg::REG_BYTES_PER_PIXEL,
              pufl_pkg::CFG_DATA_W'({pufl_pkg::BPP_W{1'b1}}));
    send(pufl_pkg::FILT_SUB, 1'b1);
    send(8'h0a, 1'b0);
    send(8'h14, 1'b0);
    send(8'hff, 1'b0);
    send(8'h01, 1'b0);
    send(8'h80, 1'b0);
    send(pufl_pkg::FILT_AVERAGE, 1'b0);
    repeat (5) send(8'hff, 1'b0);
    send(pufl_pkg::FILT_PAETH, 1'b0);
    send(8'h00, 1'b0);
    send(8'h7f, 1'b0);
    send(8'hff, 1'b0);
    send(FILT_UNKNOWN_LO, 1'b1);
    send(8'haa, 1'b0);
    send(8'h55, 1'b0);

    // row length lowered in mid row ends the row on the next byte
    drain(TAIL_CYCLES);
    cfg_write(pufl_pkg::REG_ROW_LENGTH, 2);
    send(8'h01, 1'b0);
    send(FILT_UNKNOWN_HI, 1'b0);
    send(8'h33, 1'b0);
    send(8'hcc, 1'b0);

    // random phases over several row and pixel sizes
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain(TAIL_CYCLES);
      no_gaps = ($urandom_range(0, 3) == 0);
      if (p == 0) len = 1;
      else if (p == 5) len = $urandom_range(40, 80);
      else len = $urandom_range(2, 24);
      cfg_write(pufl_pkg::REG_ROW_LENGTH, len);
      cfg_write(pufl_pkg::REG_BYTES_PER_PIXEL, $urandom_range(0, 7));
      // result side holds off while requests keep coming
      if (p == 3) begin
        no_gaps      = 1'b1;
        hold_results = 1'b1;
      end
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        if (p == 6 && n == PHASE_REQUESTS / 2) drain(0);
        req = next_request(5, 2, n == 0);
        send(req.raw_byte, req.image_start);
      end
    end

    drain(TAIL_CYCLES);
    if (tracker.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
